FILE: design/dbsp_pkg.sv
// Shared constants and types for the DHCP/BOOTP stream parser.
package dbsp_pkg;

  // Fixed header length and byte offsets within it.
  localparam logic [7:0] FIXED_LEN    = 8'd240;
  localparam logic [7:0] LAST_HDR_POS = 8'd239;
  localparam logic [7:0] POS_OPCODE   = 8'd0;
  localparam logic [7:0] POS_HWTYPE   = 8'd1;
  localparam logic [7:0] POS_HWLEN    = 8'd2;
  localparam logic [7:0] POS_XID      = 8'd7;
  localparam logic [7:0] POS_CIADDR   = 8'd15;
  localparam logic [7:0] POS_YIADDR   = 8'd19;
  localparam logic [7:0] POS_SIADDR   = 8'd23;
  localparam logic [7:0] POS_GIADDR   = 8'd27;
  localparam logic [7:0] POS_MAC      = 8'd33;
  localparam logic [7:0] POS_COOKIE0  = 8'd236;
  localparam logic [7:0] POS_COOKIE1  = 8'd237;
  localparam logic [7:0] POS_COOKIE2  = 8'd238;
  localparam logic [7:0] POS_COOKIE3  = 8'd239;

  // Magic cookie bytes.
  localparam logic [7:0] COOKIE0 = 8'd99;
  localparam logic [7:0] COOKIE1 = 8'd130;
  localparam logic [7:0] COOKIE2 = 8'd83;
  localparam logic [7:0] COOKIE3 = 8'd99;

  // Option codes.
  localparam logic [7:0] OPT_PAD      = 8'd0;
  localparam logic [7:0] OPT_END      = 8'd255;
  localparam logic [7:0] OPT_MSGTYPE  = 8'd53;
  localparam logic [7:0] OPT_REQIP    = 8'd50;
  localparam logic [7:0] OPT_SERVERID = 8'd54;
  localparam logic [7:0] OPT_LEASE    = 8'd51;
  localparam logic [7:0] OPT_ADDR_LEN = 8'd4;
  localparam logic [7:0] MAC_LEN_MAX  = 8'd6;

  // Result tags.
  localparam logic [3:0] TAG_OPCODE   = 4'd0;
  localparam logic [3:0] TAG_HWTYPE   = 4'd1;
  localparam logic [3:0] TAG_XID      = 4'd2;
  localparam logic [3:0] TAG_CIADDR   = 4'd3;
  localparam logic [3:0] TAG_YIADDR   = 4'd4;
  localparam logic [3:0] TAG_SIADDR   = 4'd5;
  localparam logic [3:0] TAG_GIADDR   = 4'd6;
  localparam logic [3:0] TAG_MAC      = 4'd7;
  localparam logic [3:0] TAG_MSGTYPE  = 4'd8;
  localparam logic [3:0] TAG_REQIP    = 4'd9;
  localparam logic [3:0] TAG_SERVERID = 4'd10;
  localparam logic [3:0] TAG_LEASE    = 4'd11;
  localparam logic [3:0] TAG_STATUS   = 4'd12;

  // Status codes.
  localparam logic [1:0] ST_ACCEPTED   = 2'd0;
  localparam logic [1:0] ST_TOO_SHORT  = 2'd1;
  localparam logic [1:0] ST_BAD_COOKIE = 2'd2;

  // Queue between parser and result stage.
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  // Work for the result stage caused by one input byte.
  typedef struct packed {
    logic        fld_vld;
    logic [3:0]  fld_tag;
    logic [47:0] fld_val;
    logic        st_vld;
    logic [1:0]  st_code;
  } entry_t;

endpackage

FILE: design/dbsp_front.sv
// Byte parser: tracks header offset, cookie and option walk, and builds result entries.
module dbsp_front import dbsp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_vld,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  output logic       ent_vld,
  output entry_t     ent
);

  typedef enum logic [1:0] {PH_CODE, PH_LEN, PH_FIRST, PH_MORE} phase_t;

  logic [7:0]  pos, pos_next;
  logic [47:0] shift, shift_next;
  logic [7:0]  hw_len, hw_len_next;
  logic        cookie, cookie_next;
  phase_t      phase, phase_next;
  logic [7:0]  cur_opt, cur_opt_next;
  logic [7:0]  left, left_next;
  logic [31:0] accum, accum_next;
  logic [7:0]  first, first_next;
  logic        stopped, stopped_next;

  logic [47:0] shift_in;

  assign shift_in = {shift[39:0], data_byte};

  always_comb begin
    pos_next     = pos;
    shift_next   = shift;
    hw_len_next  = hw_len;
    cookie_next  = cookie;
    phase_next   = phase;
    cur_opt_next = cur_opt;
    left_next    = left;
    accum_next   = accum;
    first_next   = first;
    stopped_next = stopped;
    ent          = '0;

    if (in_vld) begin
      if (pos < FIXED_LEN) begin
        shift_next = shift_in;
        pos_next   = pos + 8'd1;
        unique case (pos)
          POS_OPCODE: begin
            ent.fld_vld = 1'b1;
            ent.fld_tag = TAG_OPCODE;
            ent.fld_val = {40'd0, data_byte};
          end
          POS_HWTYPE: begin
            ent.fld_vld = 1'b1;
            ent.fld_tag = TAG_HWTYPE;
            ent.fld_val = {40'd0, data_byte};
          end
          POS_HWLEN: hw_len_next = data_byte;
          POS_XID: begin
            ent.fld_vld = 1'b1;
            ent.fld_tag = TAG_XID;
            ent.fld_val = {16'd0, shift_in[31:0]};
          end
          POS_CIADDR: begin
            ent.fld_vld = 1'b1;
            ent.fld_tag = TAG_CIADDR;
            ent.fld_val = {16'd0, shift_in[31:0]};
          end
          POS_YIADDR: begin
            ent.fld_vld = 1'b1;
            ent.fld_tag = TAG_YIADDR;
            ent.fld_val = {16'd0, shift_in[31:0]};
          end
          POS_SIADDR: begin
            ent.fld_vld = 1'b1;
            ent.fld_tag = TAG_SIADDR;
            ent.fld_val = {16'd0, shift_in[31:0]};
          end
          POS_GIADDR: begin
            ent.fld_vld = 1'b1;
            ent.fld_tag = TAG_GIADDR;
            ent.fld_val = {16'd0, shift_in[31:0]};
          end
          POS_MAC: begin
            if (hw_len != 8'd0 && hw_len <= MAC_LEN_MAX) begin
              ent.fld_vld = 1'b1;
              ent.fld_tag = TAG_MAC;
              ent.fld_val = shift_in;
            end
          end
          POS_COOKIE0: cookie_next = (data_byte == COOKIE0);
          POS_COOKIE1: cookie_next = cookie && (data_byte == COOKIE1);
          POS_COOKIE2: cookie_next = cookie && (data_byte == COOKIE2);
          POS_COOKIE3: cookie_next = cookie && (data_byte == COOKIE3);
          default: ;
        endcase
      end else if (cookie && !stopped) begin
        unique case (phase)
          PH_CODE: begin
            if (data_byte == OPT_END) begin
              stopped_next = 1'b1;
            end else if (data_byte != OPT_PAD) begin
              cur_opt_next = data_byte;
              phase_next   = PH_LEN;
            end
          end
          PH_LEN: begin
            left_next = data_byte;
            // drop address-sized options whose length is wrong
            if ((cur_opt == OPT_REQIP || cur_opt == OPT_SERVERID || cur_opt == OPT_LEASE)
                && data_byte != OPT_ADDR_LEN) begin
              cur_opt_next = 8'd0;
            end
            if (data_byte == 8'd0) begin
              phase_next = PH_CODE;
            end else begin
              accum_next = 32'd0;
              phase_next = PH_FIRST;
            end
          end
          PH_FIRST, PH_MORE: begin
            if (phase == PH_FIRST) begin
              first_next = data_byte;
              accum_next = {24'd0, data_byte};
              phase_next = PH_MORE;
            end else begin
              accum_next = {accum[23:0], data_byte};
            end
            left_next = left - 8'd1;
            if (left_next == 8'd0) begin
              phase_next = PH_CODE;
              priority if (cur_opt == OPT_MSGTYPE) begin
                ent.fld_vld = 1'b1;
                ent.fld_tag = TAG_MSGTYPE;
                ent.fld_val = {40'd0, first_next};
              end else if (cur_opt == OPT_REQIP) begin
                ent.fld_vld = 1'b1;
                ent.fld_tag = TAG_REQIP;
                ent.fld_val = {16'd0, accum_next};
              end else if (cur_opt == OPT_SERVERID) begin
                ent.fld_vld = 1'b1;
                ent.fld_tag = TAG_SERVERID;
                ent.fld_val = {16'd0, accum_next};
              end else if (cur_opt == OPT_LEASE) begin
                ent.fld_vld = 1'b1;
                ent.fld_tag = TAG_LEASE;
                ent.fld_val = {16'd0, accum_next};
              end else begin
              end
            end
          end
        endcase
      end

      if (last_byte) begin
        ent.st_vld = 1'b1;
        if (pos < LAST_HDR_POS) ent.st_code = ST_TOO_SHORT;
        else if (cookie_next) ent.st_code = ST_ACCEPTED;
        else ent.st_code = ST_BAD_COOKIE;
        // return to the start-of-packet state
        pos_next     = 8'd0;
        shift_next   = 48'd0;
        hw_len_next  = 8'd0;
        cookie_next  = 1'b0;
        phase_next   = PH_CODE;
        cur_opt_next = 8'd0;
        left_next    = 8'd0;
        accum_next   = 32'd0;
        first_next   = 8'd0;
        stopped_next = 1'b0;
      end
    end
  end

  assign ent_vld = in_vld && (ent.fld_vld || ent.st_vld);

  always_ff @(posedge clk) begin
    if (rst) begin
      pos     <= 8'd0;
      shift   <= 48'd0;
      hw_len  <= 8'd0;
      cookie  <= 1'b0;
      phase   <= PH_CODE;
      cur_opt <= 8'd0;
      left    <= 8'd0;
      accum   <= 32'd0;
      first   <= 8'd0;
      stopped <= 1'b0;
    end else begin
      pos     <= pos_next;
      shift   <= shift_next;
      hw_len  <= hw_len_next;
      cookie  <= cookie_next;
      phase   <= phase_next;
      cur_opt <= cur_opt_next;
      left    <= left_next;
      accum   <= accum_next;
      first   <= first_next;
      stopped <= stopped_next;
    end
  end

endmodule

FILE: design/dbsp_fifo.sv
// Short queue of result entries between the parser and the result stage.
module dbsp_fifo import dbsp_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   wr,
  input  entry_t din,
  input  logic   rd,
  output entry_t dout,
  output logic   full,
  output logic   empty
);

  entry_t             mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr;
  logic [FIFO_AW-1:0] rd_ptr;
  logic [FIFO_AW:0]   count;
  logic               do_wr;
  logic               do_rd;

  assign full  = (count == (FIFO_AW+1)'(FIFO_DEPTH));
  assign empty = (count == '0);
  assign do_wr = wr && !full;
  assign do_rd = rd && !empty;
  assign dout  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) mem[wr_ptr] <= din;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) wr_ptr <= wr_ptr + 1'b1;
      if (do_rd) rd_ptr <= rd_ptr + 1'b1;
      if (do_wr && !do_rd) count <= count + 1'b1;
      else if (do_rd && !do_wr) count <= count - 1'b1;
    end
  end

endmodule

FILE: design/dbsp_back.sv
// Result stage: splits each entry into field and status words behind an output register.
module dbsp_back import dbsp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        ent_vld,
  input  entry_t      ent,
  output logic        deq,
  output logic        empty,
  input  logic        pop,
  output logic [3:0]  field_tag,
  output logic [47:0] field_value,
  output logic        packet_done
);

  logic out_vld;
  logic sent_fld;
  logic load;
  logic take_fld;

  assign load     = !out_vld || pop;
  assign take_fld = ent.fld_vld && !sent_fld;
  // release the entry once its last word goes out
  assign deq      = load && ent_vld && !(take_fld && ent.st_vld);
  assign empty    = !out_vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld  <= 1'b0;
      sent_fld <= 1'b0;
    end else if (load) begin
      out_vld <= ent_vld;
      if (ent_vld) sent_fld <= take_fld && ent.st_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (load && ent_vld) begin
      if (take_fld) begin
        field_tag   <= ent.fld_tag;
        field_value <= ent.fld_val;
        packet_done <= 1'b0;
      end else begin
        field_tag   <= TAG_STATUS;
        field_value <= {46'd0, ent.st_code};
        packet_done <= 1'b1;
      end
    end
  end

endmodule

FILE: design/dhcp_bootp_stream_parser.sv
// Top level of the DHCP/BOOTP stream parser.
// Takes one message byte per cycle (push while full is low) and returns tagged
// fields and a closing status word through a queue-style result port. The parser
// handles every byte in the cycle it arrives; each byte yields zero, one or two
// result words, which drain at one word per cycle (while pop allows) from a
// 4-entry queue and an output register. A byte yields two words only when it
// is the last byte and also completes a field, so input stalls (full) only when
// the result side is popped slower than words are produced.
module dhcp_bootp_stream_parser import dbsp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output logic        empty,
  input  logic        pop,
  output logic [3:0]  field_tag,
  output logic [47:0] field_value,
  output logic        packet_done
);

  logic   accept;
  logic   fr_vld;
  entry_t fr_ent;
  logic   q_empty;
  entry_t q_ent;
  logic   deq;

  assign accept = push && !full;

  dbsp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_vld    (accept),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .ent_vld   (fr_vld),
    .ent       (fr_ent)
  );

  dbsp_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .wr    (fr_vld),
    .din   (fr_ent),
    .rd    (deq),
    .dout  (q_ent),
    .full  (full),
    .empty (q_empty)
  );

  dbsp_back u_back (
    .clk         (clk),
    .rst         (rst),
    .ent_vld     (!q_empty),
    .ent         (q_ent),
    .deq         (deq),
    .empty       (empty),
    .pop         (pop),
    .field_tag   (field_tag),
    .field_value (field_value),
    .packet_done (packet_done)
  );

endmodule
